// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: command codes,
// sequencer states, character codes and field widths.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Default screen geometry
	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;

	// One cell: character in the low byte, attribute in the high byte
	localparam int CELL_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int CURSOR_W = 11;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	// Attribute after reset
	localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h1F;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_SETXY = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCROLL,
		ST_CLEAR,
		ST_FIN
	} state_t;

	typedef logic [CELL_W-1:0] cell_t;

	function automatic cell_t make_cell(input logic [BYTE_W-1:0] c,
		input logic [BYTE_W-1:0] a);
		make_cell = {a, c};
	endfunction

endpackage

// ===== hdl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console with a character/attribute screen store, a logical
// column and row, and a hardware cursor register.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (cmd, ch, fill_attrib, pos_x, pos_y) are taken when in_valid
//   is high and in_stall low. Each word yields one output word (cursor_x,
//   cursor_y, hw_cursor, cell_char, cell_attrib), taken when out_valid is
//   high and out_stall low. cfg_data writes the text attribute on a
//   cfg_valid/cfg_ready handshake; write it only while the block is idle.
//   Put char, set position and read cell are accepted, then their result is
//   loaded into the output register. Clear walks the whole store, one cell a
//   cycle. A put char that moves below the last row scrolls: one copy or fill
//   write per cycle over the store. No new word is accepted until the
//   sequencer is back in idle. The single store write port sets this pace.
//   Reset clears column, row, hardware cursor and the output valid and
//   sets the attribute to 0x1F; screen cells are undefined until written.
//   While the receiver stalls, the output word holds; the next input word is
//   still accepted and worked on, and its result waits until the output
//   register frees.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLS = tcw_pkg::COLS_DEF,
	parameter int ROWS = tcw_pkg::ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  ch,
	input  logic [7:0]  fill_attrib,
	input  logic [6:0]  pos_x,
	input  logic [4:0]  pos_y,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  cursor_x,
	output logic [4:0]  cursor_y,
	output logic [10:0] hw_cursor,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attrib,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int N  = COLS * ROWS;
	localparam int AW = $clog2(N);
	localparam int PW = $clog2(N + 1);
	localparam int CW = $clog2(COLS + 1);
	localparam int RW = $clog2(ROWS);

	localparam logic [CW-1:0] COL_END   = CW'(COLS);
	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [PW-1:0] COLS_P    = PW'(COLS);
	localparam logic [PW-1:0] N_P       = PW'(N);
	localparam logic [PW-1:0] COPY_END  = PW'(N - COLS);
	localparam logic [7:0]    COLS_8    = 8'(COLS);
	localparam logic [7:0]    COLS_M1_8 = 8'(COLS - 1);
	localparam logic [5:0]    ROWS_M1_6 = 6'(ROWS - 1);

	tcw_pkg::state_t state_q, state_d;

	logic [CW-1:0]              column_q;
	logic [RW-1:0]              row_q;
	logic [tcw_pkg::CURSOR_W-1:0] cursor_q;
	logic [7:0]                 attrib_q;
	logic [7:0]                 fill_q;
	logic [PW-1:0]              sweep_q;
	logic                       pend_q;
	logic [7:0]                 pend_ch_q;
	logic                       rd_flag_q;

	logic                       out_valid_q;
	logic [6:0]                 out_x_q;
	logic [4:0]                 out_y_q;
	logic [10:0]                out_cur_q;
	logic [7:0]                 out_char_q;
	logic [7:0]                 out_attr_q;

	logic                       in_fire;
	logic                       fin_load;

	// put char datapath
	logic                       is_nl, printable, adv, row_is_last, scroll;
	logic [RW-1:0]              pc_row;
	logic [CW-1:0]              pc_col_base, pc_col;
	logic [PW-1:0]              pc_base, pc_wpos, pc_cursor;

	// set position and read cell clamps
	logic [7:0]                 px_ext;
	logic [5:0]                 py_ext;
	logic [CW-1:0]              set_col, rd_col;
	logic [RW-1:0]              set_row;
	logic [PW-1:0]              rd_pos;

	// store port
	logic                       mem_we, mem_re;
	logic [AW-1:0]              mem_waddr, mem_raddr;
	tcw_pkg::cell_t             mem_wdata, mem_rdata;
	logic [PW-1:0]              sweep_wpos;

	// sequencer controls
	logic                       load_pos, load_cursor, start_sweep, step_sweep, load_pend;
	logic [CW-1:0]              col_d;
	logic [RW-1:0]              row_d;

	assign in_fire   = in_valid && !in_stall;
	assign in_stall  = (state_q != tcw_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	// Compute put char target and new position
	always_comb begin
		is_nl       = (ch == tcw_pkg::CH_LF) || (ch == tcw_pkg::CH_CR);
		printable   = (ch != tcw_pkg::CH_NUL) && !is_nl;
		adv         = is_nl || (printable && (column_q == COL_END));
		row_is_last = (row_q == ROW_LAST);
		scroll      = adv && row_is_last;
		pc_row      = (adv && !row_is_last) ? row_q + RW'(1) : row_q;
		pc_col_base = adv ? '0 : column_q;
		pc_col      = printable ? pc_col_base + CW'(1) : pc_col_base;
		pc_base     = PW'(PW'(pc_row) * COLS_P);
		pc_wpos     = pc_base + PW'(pc_col_base);
		pc_cursor   = pc_base + PW'(pc_col);
	end

	// Clamp positions for set position and read cell
	always_comb begin
		px_ext  = {1'b0, pos_x};
		py_ext  = {1'b0, pos_y};
		set_col = (px_ext > COLS_8) ? COL_END : CW'(px_ext);
		set_row = (py_ext > ROWS_M1_6) ? ROW_LAST : RW'(py_ext);
		rd_col  = (px_ext > COLS_M1_8) ? CW'(COLS_M1_8) : CW'(px_ext);
		rd_pos  = PW'(PW'(set_row) * COLS_P) + PW'(rd_col);
	end

	assign sweep_wpos = sweep_q - PW'(1);

	// Next state, store accesses and register load enables
	always_comb begin
		state_d     = state_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_waddr   = '0;
		mem_raddr   = '0;
		mem_wdata   = tcw_pkg::make_cell(tcw_pkg::CH_SPACE, attrib_q);
		load_pos    = 1'b0;
		load_cursor = 1'b0;
		load_pend   = 1'b0;
		start_sweep = 1'b0;
		step_sweep  = 1'b0;
		col_d       = column_q;
		row_d       = row_q;
		fin_load    = 1'b0;
		unique case (state_q)
			tcw_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = tcw_pkg::ST_FIN;
					unique case (tcw_pkg::cmd_t'(cmd))
						tcw_pkg::CMD_PUT: begin
							if (ch != tcw_pkg::CH_NUL) begin
								load_pos    = 1'b1;
								load_cursor = 1'b1;
								col_d       = pc_col;
								row_d       = pc_row;
								if (scroll) begin
									load_pend   = 1'b1;
									start_sweep = 1'b1;
									state_d     = tcw_pkg::ST_SCROLL;
								end else if (printable) begin
									mem_we    = 1'b1;
									mem_waddr = AW'(pc_wpos);
									mem_wdata = tcw_pkg::make_cell(ch, attrib_q);
								end
							end
						end
						tcw_pkg::CMD_CLEAR: begin
							load_pos    = 1'b1;
							col_d       = '0;
							row_d       = '0;
							start_sweep = 1'b1;
							state_d     = tcw_pkg::ST_CLEAR;
						end
						tcw_pkg::CMD_SETXY: begin
							load_pos = 1'b1;
							col_d    = set_col;
							row_d    = set_row;
						end
						tcw_pkg::CMD_READ: begin
							mem_re    = 1'b1;
							mem_raddr = AW'(rd_pos);
						end
						default: ;
					endcase
				end
			end
			tcw_pkg::ST_SCROLL: begin
				// read one row ahead, write the word read last cycle
				step_sweep = 1'b1;
				if (sweep_q < COPY_END) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(sweep_q + COLS_P);
				end
				if (sweep_q != '0) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(sweep_wpos);
					if (sweep_wpos < COPY_END) begin
						mem_wdata = mem_rdata;
					end else if (sweep_wpos == COPY_END && pend_q) begin
						mem_wdata = tcw_pkg::make_cell(pend_ch_q, attrib_q);
					end
				end
				if (sweep_q == N_P) begin
					state_d = tcw_pkg::ST_FIN;
				end
			end
			tcw_pkg::ST_CLEAR: begin
				step_sweep = 1'b1;
				mem_we     = 1'b1;
				mem_waddr  = AW'(sweep_q);
				mem_wdata  = tcw_pkg::make_cell(tcw_pkg::CH_SPACE, fill_q);
				if (sweep_q == N_P - PW'(1)) begin
					state_d = tcw_pkg::ST_FIN;
				end
			end
			tcw_pkg::ST_FIN: begin
				// hand the result over once the output register is free
				if (!out_valid_q || !out_stall) begin
					fin_load = 1'b1;
					state_d  = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Logical position, hardware cursor and attribute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			cursor_q <= '0;
			attrib_q <= tcw_pkg::ATTR_RESET;
		end else begin
			if (load_pos) begin
				column_q <= col_d;
				row_q    <= row_d;
			end
			if (load_cursor) begin
				cursor_q <= tcw_pkg::CURSOR_W'(pc_cursor);
			end
			if (cfg_valid && cfg_ready) begin
				attrib_q <= cfg_data;
			end
		end
	end

	// Sweep counter and item flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= '0;
			rd_flag_q <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			if (start_sweep) begin
				sweep_q <= '0;
			end else if (step_sweep) begin
				sweep_q <= sweep_q + PW'(1);
			end
			if (in_fire) begin
				rd_flag_q <= (tcw_pkg::cmd_t'(cmd) == tcw_pkg::CMD_READ);
			end
			if (load_pend) begin
				pend_q <= printable;
			end
		end
	end

	// Item payload held for the sweeps
	always_ff @(posedge clk) begin
		if (in_fire) begin
			fill_q    <= fill_attrib;
			pend_ch_q <= ch;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_x_q    <= 7'(column_q);
			out_y_q    <= 5'(row_q);
			out_cur_q  <= cursor_q;
			out_char_q <= rd_flag_q ? mem_rdata[7:0] : '0;
			out_attr_q <= rd_flag_q ? mem_rdata[15:8] : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign cursor_x    = out_x_q;
	assign cursor_y    = out_y_q;
	assign hw_cursor   = out_cur_q;
	assign cell_char   = out_char_q;
	assign cell_attrib = out_attr_q;

	tcw_screen_ram #(
		.DEPTH  (N),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Column never passes the wrap position, row never passes the last row
	assert property (@(posedge clk) disable iff (!arst_n)
		(column_q <= COL_END) && (row_q <= ROW_LAST))
		else $error("logical position out of range");

	// Store writes stay inside the screen
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (PW'(mem_waddr) < N_P))
		else $error("store write beyond screen");

	// Sweep counter stays within one pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::ST_SCROLL || state_q == tcw_pkg::ST_CLEAR) |-> (sweep_q <= N_P))
		else $error("sweep counter overrun");

	// An accepted word always moves the sequencer out of idle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != tcw_pkg::ST_IDLE))
		else $error("accepted word not processed");

	// A finished result is loaded only into a free or draining output register
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten while stalled");

endmodule

// ===== hdl/tcw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
	parameter int DEPTH  = tcw_pkg::COLS_DEF * tcw_pkg::ROWS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  tcw_pkg::cell_t      wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output tcw_pkg::cell_t      rdata
);

	tcw_pkg::cell_t mem [DEPTH];
	tcw_pkg::cell_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
